[design/pbba_pkg.sv]
// ----------------------------------------------------------------------------
// pbba_pkg
// Types and constants shared by the point box image bbox accumulator
// ----------------------------------------------------------------------------
`default_nettype none
package pbba_pkg;

    localparam logic [1:0] OP_LOAD   = 2'd0;
    localparam logic [1:0] OP_POINT  = 2'd1;
    localparam logic [1:0] OP_FLUSH  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] REG_FOCAL_X  = 3'd0;
    localparam logic [2:0] REG_SKEW     = 3'd1;
    localparam logic [2:0] REG_CENTER_X = 3'd2;
    localparam logic [2:0] REG_FOCAL_Y  = 3'd3;
    localparam logic [2:0] REG_CENTER_Y = 3'd4;

    localparam logic signed [15:0] EMPTY_LOW  = 16'sd10000;
    localparam logic signed [15:0] EMPTY_HIGH = -16'sd10000;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [2:0]         slot;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
        logic signed [31:0] upper_x;
        logic signed [31:0] upper_y;
        logic signed [31:0] upper_z;
    } in_item_t;

    typedef struct packed {
        logic               kind;
        logic               hit;
        logic [2:0]         box_index;
        logic signed [15:0] pixel_u;
        logic signed [15:0] pixel_v;
        logic signed [15:0] min_u;
        logic signed [15:0] min_v;
        logic signed [15:0] max_u;
        logic signed [15:0] max_v;
        logic               last;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SEARCH, ST_MUL, ST_DIV_INIT, ST_DIV, ST_SAT,
        ST_UPDATE, ST_POINT_OUT, ST_FLUSH, ST_WAIT
    } state_t;

endpackage
`default_nettype wire

[design/point_box_image_bbox_accumulator_top.sv]
// ----------------------------------------------------------------------------
// point_box_image_bbox_accumulator_top
// Box membership test, pinhole projection and per-box pixel extents
// ----------------------------------------------------------------------------
//  channel  direction  ports
//  s_       in         s_valid s_ready s_data
//  m_       out        m_valid m_ready m_data
//  cfg      in         cfg_valid cfg_ready cfg_index cfg_data
//
// load: written as the item is taken. point: the boxes are searched in index order,
// then products are summed through one shared multiplier and two 48-step restoring
// divisions run through one shared divider. flush: one summary per cycle while m_ready is high.
// aresetn is synchronous; it clears valid bits, extents and control state.
// a stalled result holds in the output register; no new item is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module point_box_image_bbox_accumulator_top #(
    parameter int NBOX = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire pbba_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output pbba_pkg::out_item_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [31:0]         cfg_data
);
    localparam int IW = (NBOX > 1) ? $clog2(NBOX) : 1;
    localparam int NSUM = (NBOX < 8) ? NBOX : 8;

    pbba_pkg::state_t state_reg, state_next;

    logic signed [31:0] fx_reg, sk_reg, cx_reg, fy_reg, cy_reg;

    logic               valid_reg [NBOX];
    logic signed [31:0] lx_reg [NBOX], ly_reg [NBOX], lz_reg [NBOX];
    logic signed [31:0] hx_reg [NBOX], hy_reg [NBOX], hz_reg [NBOX];
    logic signed [15:0] mnu_reg [NBOX], mnv_reg [NBOX], mxu_reg [NBOX], mxv_reg [NBOX];

    logic signed [31:0] px_reg, py_reg, pz_reg;
    logic [IW-1:0]      idx_reg;
    logic [2:0]         step_reg;
    logic               found_reg;
    logic [IW-1:0]      fidx_reg;
    logic signed [65:0] accu_reg, accv_reg;
    logic               sel_v_reg;
    logic [65:0]        rem_reg;
    logic [47:0]        quo_reg;
    logic [47:0]        dvs_reg;
    logic [5:0]         cnt_reg;
    logic               qneg_reg;
    logic signed [15:0] u_reg, v_reg;
    logic               out_valid_reg;
    pbba_pkg::out_item_t out_reg;

    // shared multiplier operands
    logic signed [31:0] ma, mb;
    logic signed [63:0] prod;
    always_comb begin
        case (step_reg)
            3'd0:    begin ma = fx_reg; mb = px_reg; end
            3'd1:    begin ma = sk_reg; mb = py_reg; end
            3'd2:    begin ma = cx_reg; mb = pz_reg; end
            3'd3:    begin ma = fy_reg; mb = py_reg; end
            default: begin ma = cy_reg; mb = pz_reg; end
        endcase
        prod = ma * mb;
    end

    logic inside_box;
    always_comb begin
        inside_box = valid_reg[idx_reg] &&
            px_reg >= lx_reg[idx_reg] && px_reg < hx_reg[idx_reg] &&
            py_reg >= ly_reg[idx_reg] && py_reg < hy_reg[idx_reg] &&
            pz_reg >= lz_reg[idx_reg] && pz_reg < hz_reg[idx_reg];
    end

    logic signed [65:0] num;
    logic [65:0]        num_mag;
    logic [66:0]        trial;
    logic [65:0]        rem_sh;
    logic signed [15:0] sat_q;
    always_comb begin
        num = sel_v_reg ? accv_reg : accu_reg;
        num_mag = num[65] ? 66'(-num) : num;
        rem_sh = {rem_reg[64:0], quo_reg[47]};
        trial = {1'b0, rem_sh} - {19'd0, dvs_reg};
        if (qneg_reg) begin
            sat_q = (quo_reg > 48'd32768) ? -16'sd32768 : 16'(-quo_reg);
        end else begin
            sat_q = (quo_reg > 48'd32767) ? 16'sd32767 : 16'(quo_reg);
        end
    end

    logic [47:0] zmag;
    assign zmag = {(pz_reg[31] ? 32'(-pz_reg) : 32'(pz_reg)), 16'd0};

    logic last_idx;
    assign last_idx = (32'(idx_reg) == NBOX - 1);
    logic last_sum;
    assign last_sum = (32'(idx_reg) == NSUM - 1);

    assign s_ready   = (state_reg == pbba_pkg::ST_IDLE) && !out_valid_reg;
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pbba_pkg::ST_IDLE: begin
                if (s_valid && s_ready) begin
                    if (s_data.opcode == pbba_pkg::OP_POINT) begin
                        state_next = pbba_pkg::ST_SEARCH;
                    end else if (s_data.opcode == pbba_pkg::OP_FLUSH) begin
                        state_next = pbba_pkg::ST_FLUSH;
                    end
                end
            end
            pbba_pkg::ST_SEARCH: begin
                if (inside_box) begin
                    state_next = (pz_reg == 32'sd0) ? pbba_pkg::ST_POINT_OUT
                                                    : pbba_pkg::ST_MUL;
                end else if (last_idx) begin
                    state_next = pbba_pkg::ST_POINT_OUT;
                end
            end
            pbba_pkg::ST_MUL: begin
                if (step_reg == 3'd4) state_next = pbba_pkg::ST_DIV_INIT;
            end
            pbba_pkg::ST_DIV_INIT: state_next = pbba_pkg::ST_DIV;
            pbba_pkg::ST_DIV: begin
                if (cnt_reg == 6'd47) state_next = pbba_pkg::ST_SAT;
            end
            pbba_pkg::ST_SAT: begin
                state_next = sel_v_reg ? pbba_pkg::ST_UPDATE : pbba_pkg::ST_DIV_INIT;
            end
            pbba_pkg::ST_UPDATE: state_next = pbba_pkg::ST_POINT_OUT;
            pbba_pkg::ST_POINT_OUT: state_next = pbba_pkg::ST_WAIT;
            pbba_pkg::ST_FLUSH: begin
                if (!out_valid_reg || m_ready) begin
                    if (last_sum) state_next = pbba_pkg::ST_WAIT;
                end
            end
            pbba_pkg::ST_WAIT: begin
                if (!out_valid_reg || m_ready) state_next = pbba_pkg::ST_IDLE;
            end
            default: state_next = pbba_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pbba_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fx_reg <= '0; sk_reg <= '0; cx_reg <= '0; fy_reg <= '0; cy_reg <= '0;
        end else if (cfg_valid) begin
            case (cfg_index)
                pbba_pkg::REG_FOCAL_X:  fx_reg <= cfg_data;
                pbba_pkg::REG_SKEW:     sk_reg <= cfg_data;
                pbba_pkg::REG_CENTER_X: cx_reg <= cfg_data;
                pbba_pkg::REG_FOCAL_Y:  fy_reg <= cfg_data;
                pbba_pkg::REG_CENTER_Y: cy_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == pbba_pkg::ST_IDLE && s_valid && s_ready &&
            s_data.opcode == pbba_pkg::OP_LOAD && 32'(s_data.slot) < NBOX) begin
            lx_reg[IW'(s_data.slot)] <= s_data.coord_x;
            ly_reg[IW'(s_data.slot)] <= s_data.coord_y;
            lz_reg[IW'(s_data.slot)] <= s_data.coord_z;
            hx_reg[IW'(s_data.slot)] <= s_data.upper_x;
            hy_reg[IW'(s_data.slot)] <= s_data.upper_y;
            hz_reg[IW'(s_data.slot)] <= s_data.upper_z;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NBOX; i++) begin
                valid_reg[i] <= 1'b0;
                mnu_reg[i] <= pbba_pkg::EMPTY_LOW;
                mnv_reg[i] <= pbba_pkg::EMPTY_LOW;
                mxu_reg[i] <= pbba_pkg::EMPTY_HIGH;
                mxv_reg[i] <= pbba_pkg::EMPTY_HIGH;
            end
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == pbba_pkg::ST_POINT_OUT ||
                (state_reg == pbba_pkg::ST_FLUSH && (!out_valid_reg || m_ready))) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                pbba_pkg::ST_IDLE: begin
                    if (s_valid && s_ready && s_data.opcode == pbba_pkg::OP_LOAD &&
                        32'(s_data.slot) < NBOX) begin
                        valid_reg[IW'(s_data.slot)] <= 1'b1;
                    end
                end
                pbba_pkg::ST_UPDATE: begin
                    if (u_reg < mnu_reg[fidx_reg]) mnu_reg[fidx_reg] <= u_reg;
                    if (u_reg > mxu_reg[fidx_reg]) mxu_reg[fidx_reg] <= u_reg;
                    if (v_reg < mnv_reg[fidx_reg]) mnv_reg[fidx_reg] <= v_reg;
                    if (v_reg > mxv_reg[fidx_reg]) mxv_reg[fidx_reg] <= v_reg;
                end
                pbba_pkg::ST_FLUSH: begin
                    if ((!out_valid_reg || m_ready) && last_sum) begin
                        for (int i = 0; i < NBOX; i++) begin
                            mnu_reg[i] <= pbba_pkg::EMPTY_LOW;
                            mnv_reg[i] <= pbba_pkg::EMPTY_LOW;
                            mxu_reg[i] <= pbba_pkg::EMPTY_HIGH;
                            mxv_reg[i] <= pbba_pkg::EMPTY_HIGH;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            pbba_pkg::ST_IDLE: begin
                px_reg <= s_data.coord_x;
                py_reg <= s_data.coord_y;
                pz_reg <= s_data.coord_z;
                idx_reg <= '0;
                step_reg <= '0;
                found_reg <= 1'b0;
                fidx_reg <= '0;
                accu_reg <= '0;
                accv_reg <= '0;
                sel_v_reg <= 1'b0;
                u_reg <= '0;
                v_reg <= '0;
            end
            pbba_pkg::ST_SEARCH: begin
                if (inside_box) begin
                    found_reg <= (pz_reg != 32'sd0);
                    fidx_reg <= idx_reg;
                end else begin
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            pbba_pkg::ST_MUL: begin
                if (step_reg < 3'd3) accu_reg <= accu_reg + 66'(prod);
                else accv_reg <= accv_reg + 66'(prod);
                step_reg <= step_reg + 3'd1;
            end
            pbba_pkg::ST_DIV_INIT: begin
                quo_reg <= num_mag[47:0];
                rem_reg <= {48'd0, num_mag[65:48]};
                dvs_reg <= zmag;
                cnt_reg <= '0;
                qneg_reg <= num[65] ^ pz_reg[31];
            end
            pbba_pkg::ST_DIV: begin
                if (!trial[66]) begin
                    rem_reg <= trial[65:0];
                    quo_reg <= {quo_reg[46:0], 1'b1};
                end else begin
                    rem_reg <= rem_sh;
                    quo_reg <= {quo_reg[46:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
            end
            pbba_pkg::ST_SAT: begin
                if (sel_v_reg) v_reg <= sat_q;
                else u_reg <= sat_q;
                sel_v_reg <= 1'b1;
            end
            pbba_pkg::ST_POINT_OUT: begin
                out_reg.kind <= 1'b0;
                out_reg.hit <= found_reg;
                out_reg.box_index <= found_reg ? 3'(fidx_reg) : 3'd0;
                out_reg.pixel_u <= found_reg ? u_reg : 16'sd0;
                out_reg.pixel_v <= found_reg ? v_reg : 16'sd0;
                out_reg.min_u <= '0;
                out_reg.min_v <= '0;
                out_reg.max_u <= '0;
                out_reg.max_v <= '0;
                out_reg.last <= 1'b1;
            end
            pbba_pkg::ST_FLUSH: begin
                if (!out_valid_reg || m_ready) begin
                    out_reg.kind <= 1'b1;
                    out_reg.hit <= valid_reg[idx_reg] &&
                                   (mnu_reg[idx_reg] <= mxu_reg[idx_reg]);
                    out_reg.box_index <= 3'(idx_reg);
                    out_reg.pixel_u <= '0;
                    out_reg.pixel_v <= '0;
                    out_reg.min_u <= mnu_reg[idx_reg];
                    out_reg.min_v <= mnv_reg[idx_reg];
                    out_reg.max_u <= mxu_reg[idx_reg];
                    out_reg.max_v <= mxv_reg[idx_reg];
                    out_reg.last <= last_sum;
                    idx_reg <= idx_reg + IW'(1);
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

[test/point_box_image_bbox_accumulator_top_tb.sv]
// ----------------------------------------------------------------------------
// point_box_image_bbox_accumulator_top_tb
// Self-checking bench: loads boxes, sends points and flushes under several
// camera matrices, predicts each result and compares the whole result item.
// ----------------------------------------------------------------------------
`default_nettype none

class pixel_extent_board;
    pbba_pkg::out_item_t pending[$];
    bit                  box_on[8];
    logic signed [31:0]  lo_x[8], lo_y[8], lo_z[8], hi_x[8], hi_y[8], hi_z[8];
    int                  col_lo[8], row_lo[8], col_hi[8], row_hi[8];
    logic signed [31:0]  fx, sk, cx, fy, cy;
    int                  mismatches;

    function new();
        mismatches = 0;
        fx = 0; sk = 0; cx = 0; fy = 0; cy = 0;
        for (int i = 0; i < 8; i++) begin
            box_on[i] = 0;
            col_lo[i] = 10000; row_lo[i] = 10000;
            col_hi[i] = -10000; row_hi[i] = -10000;
        end
    endfunction

    function void set_reg(logic [2:0] idx, logic [31:0] val);
        case (idx)
            pbba_pkg::REG_FOCAL_X:  fx = val;
            pbba_pkg::REG_SKEW:     sk = val;
            pbba_pkg::REG_CENTER_X: cx = val;
            pbba_pkg::REG_FOCAL_Y:  fy = val;
            pbba_pkg::REG_CENTER_Y: cy = val;
            default: ;
        endcase
    endfunction

    function int div_sat(logic signed [127:0] num, logic signed [31:0] z);
        logic signed [127:0] d;
        logic signed [127:0] q;
        d = 128'(z) <<< 16;
        q = num / d;
        if (q > 32767) return 32767;
        if (q < -32768) return -32768;
        return int'(q);
    endfunction

    function void note_item(pbba_pkg::in_item_t it);
        pbba_pkg::out_item_t r;
        int found, u, v;
        logic signed [127:0] nu, nv;
        r = '0;
        case (it.opcode)
            pbba_pkg::OP_LOAD: begin
                box_on[it.slot] = 1;
                lo_x[it.slot] = it.coord_x; lo_y[it.slot] = it.coord_y;
                lo_z[it.slot] = it.coord_z; hi_x[it.slot] = it.upper_x;
                hi_y[it.slot] = it.upper_y; hi_z[it.slot] = it.upper_z;
            end
            pbba_pkg::OP_POINT: begin
                found = -1; u = 0; v = 0;
                for (int i = 0; i < 8 && found < 0; i++)
                    if (box_on[i] && it.coord_x >= lo_x[i] && it.coord_x < hi_x[i] &&
                        it.coord_y >= lo_y[i] && it.coord_y < hi_y[i] &&
                        it.coord_z >= lo_z[i] && it.coord_z < hi_z[i])
                        found = i;
                if (it.coord_z == 0) found = -1;
                if (found >= 0) begin
                    nu = 128'(fx) * 128'(it.coord_x) + 128'(sk) * 128'(it.coord_y)
                       + 128'(cx) * 128'(it.coord_z);
                    nv = 128'(fy) * 128'(it.coord_y) + 128'(cy) * 128'(it.coord_z);
                    u = div_sat(nu, it.coord_z);
                    v = div_sat(nv, it.coord_z);
                    if (u < col_lo[found]) col_lo[found] = u;
                    if (u > col_hi[found]) col_hi[found] = u;
                    if (v < row_lo[found]) row_lo[found] = v;
                    if (v > row_hi[found]) row_hi[found] = v;
                    r.hit = 1;
                    r.box_index = 3'(found);
                end
                r.pixel_u = 16'(u);
                r.pixel_v = 16'(v);
                r.last = 1;
                pending.insert(pending.size(), r);
            end
            pbba_pkg::OP_FLUSH: begin
                for (int k = 0; k < 8; k++) begin
                    r = '0;
                    r.kind = 1;
                    r.hit = box_on[k] && (col_lo[k] <= col_hi[k]);
                    r.box_index = 3'(k);
                    r.min_u = 16'(col_lo[k]); r.min_v = 16'(row_lo[k]);
                    r.max_u = 16'(col_hi[k]); r.max_v = 16'(row_hi[k]);
                    r.last = (k == 7);
                    pending.insert(pending.size(), r);
                    col_lo[k] = 10000; row_lo[k] = 10000;
                    col_hi[k] = -10000; row_hi[k] = -10000;
                end
            end
            default: ;
        endcase
    endfunction

    function void check_result(pbba_pkg::out_item_t got);
        pbba_pkg::out_item_t exp_r;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        exp_r = pending.pop_front();
        if (got !== exp_r) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, got);
        end
    endfunction
endclass

module point_box_image_bbox_accumulator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic                aclk = 0, aresetn = 0;
    logic                s_valid = 0, s_ready, m_valid, m_ready = 0;
    pbba_pkg::in_item_t  s_data = '0;
    pbba_pkg::out_item_t m_data;
    logic                cfg_valid = 0, cfg_ready;
    logic [2:0]          cfg_index = '0;
    logic [31:0]         cfg_data = '0;

    pixel_extent_board board = new();
    int  quiet_cycles = 0;
    bit  calm = 0;
    int  watchdog_limit = 20000;

    point_box_image_bbox_accumulator_top DUT (.*);

    always begin
        #10 aclk = 1;
        #10 aclk = 0;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_result(m_data);
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > watchdog_limit) begin
            $display("point_box_image_bbox_accumulator_top_tb failed");
            $finish;
        end
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
    end

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_valid <= 1; cfg_index <= idx; cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        board.set_reg(idx, val);
    endtask

    task automatic send_item(pbba_pkg::in_item_t it);
        while (!calm && $urandom_range(99) < 8) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1; s_data <= it;
        do @(posedge aclk); while (!s_ready);
        board.note_item(it);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    function automatic pbba_pkg::in_item_t box_item(int s, int lx, int ly, int lz,
                                                    int hx, int hy, int hz);
        pbba_pkg::in_item_t it;
        it = '0; it.opcode = pbba_pkg::OP_LOAD; it.slot = 3'(s);
        it.coord_x = lx; it.coord_y = ly; it.coord_z = lz;
        it.upper_x = hx; it.upper_y = hy; it.upper_z = hz;
        return it;
    endfunction

    function automatic pbba_pkg::in_item_t pt_item(int x, int y, int z);
        pbba_pkg::in_item_t it;
        it = '0; it.opcode = pbba_pkg::OP_POINT;
        it.coord_x = x; it.coord_y = y; it.coord_z = z;
        it.slot = 3'($urandom); it.upper_x = $urandom;
        it.upper_y = $urandom; it.upper_z = $urandom;
        return it;
    endfunction

    function automatic pbba_pkg::in_item_t op_item(logic [1:0] op);
        pbba_pkg::in_item_t it;
        it = '0; it.opcode = op; it.slot = 3'($urandom);
        it.coord_x = $urandom; it.coord_y = $urandom; it.coord_z = $urandom;
        return it;
    endfunction

    function automatic int near_box(int lo, int hi);
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return lo;
        if (r == 1) return hi;
        if (r == 2) return hi - 1;
        if (r == 3) return $urandom;
        return lo + int'($urandom_range(hi - lo));
    endfunction

    task automatic set_camera(int p);
        case (p)
            0: begin
                write_reg(pbba_pkg::REG_FOCAL_X, 32'sd500 <<< 16);
                write_reg(pbba_pkg::REG_SKEW, 0);
                write_reg(pbba_pkg::REG_CENTER_X, 32'sd320 <<< 16);
                write_reg(pbba_pkg::REG_FOCAL_Y, 32'sd500 <<< 16);
                write_reg(pbba_pkg::REG_CENTER_Y, 32'sd240 <<< 16);
            end
            1: begin
                write_reg(pbba_pkg::REG_FOCAL_X, 32'h7fffffff);
                write_reg(pbba_pkg::REG_SKEW, 32'h80000000);
                write_reg(pbba_pkg::REG_CENTER_X, 32'h7fffffff);
                write_reg(pbba_pkg::REG_FOCAL_Y, 32'h80000000);
                write_reg(pbba_pkg::REG_CENTER_Y, 32'h80000000);
            end
            default: begin
                write_reg(pbba_pkg::REG_FOCAL_X, $urandom);
                write_reg(pbba_pkg::REG_SKEW, $urandom_range(65535) - 32768);
                write_reg(pbba_pkg::REG_CENTER_X, $urandom);
                write_reg(pbba_pkg::REG_FOCAL_Y, $urandom_range(32'h3ffffff));
                write_reg(pbba_pkg::REG_CENTER_Y, $urandom);
            end
        endcase
        cfg_valid <= 0;
    endtask

    initial begin
        int s, bl[8][6];
        repeat (3) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        set_camera(0);
        // directed
        send_item(pt_item(0, 0, 32'sd1 <<< 16));
        send_item(op_item(pbba_pkg::OP_FLUSH));
        send_item(box_item(0, -(32'sd2 <<< 16), -(32'sd2 <<< 16), 32'sd1 <<< 16,
                           32'sd2 <<< 16, 32'sd2 <<< 16, 32'sd10 <<< 16));
        send_item(box_item(1, 32'h80000000, 32'h80000000, 32'h80000000,
                           32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        send_item(box_item(2, 5, 5, 5, 5, 9, 9));
        send_item(pt_item(0, 0, 32'sd1 <<< 16));
        send_item(pt_item(-(32'sd2 <<< 16), -(32'sd2 <<< 16), 32'sd1 <<< 16));
        send_item(pt_item(32'sd2 <<< 16, 0, 32'sd2 <<< 16));
        send_item(pt_item(0, 0, 0));
        send_item(pt_item(32'h7fffffff, 32'h80000000, 1));
        send_item(pt_item(32'h80000000, 32'h7fffffff, -1));
        send_item(pt_item(5, 6, 6));
        send_item(op_item(pbba_pkg::OP_UNUSED));
        send_item(op_item(pbba_pkg::OP_FLUSH));
        drain();
        set_camera(1);
        send_item(pt_item(32'h7fffffff, 32'h7fffffff, 32'h80000000));
        send_item(pt_item(1, -1, 32'h7ffffffe));
        send_item(op_item(pbba_pkg::OP_FLUSH));
        drain();
        // random
        for (int ph = 0; ph < 4; ph++) begin
            set_camera(ph == 3 ? 0 : 2);
            calm = (ph == 1);
            for (int i = 0; i < 8; i++) begin
                bl[i][0] = $urandom_range(32'h3ffff) - 32'h20000;
                bl[i][1] = $urandom_range(32'h3ffff) - 32'h20000;
                bl[i][2] = $urandom_range(32'h3ffff) - 32'h10000;
                bl[i][3] = bl[i][0] + $urandom_range(32'h40000);
                bl[i][4] = bl[i][1] + $urandom_range(32'h40000);
                bl[i][5] = bl[i][2] + $urandom_range(32'h40000);
                send_item(box_item(i, bl[i][0], bl[i][1], bl[i][2],
                                   bl[i][3], bl[i][4], bl[i][5]));
            end
            for (int n = 0; n < 80; n++) begin
                s = $urandom_range(7);
                case ($urandom_range(19))
                    0: send_item(op_item(pbba_pkg::OP_FLUSH));
                    1: send_item(op_item(pbba_pkg::OP_UNUSED));
                    2: send_item(box_item(s, $urandom, $urandom, $urandom,
                                          $urandom, $urandom, $urandom));
                    3: send_item(pt_item($urandom, $urandom, $urandom));
                    default: send_item(pt_item(near_box(bl[s][0], bl[s][3]),
                                               near_box(bl[s][1], bl[s][4]),
                                               near_box(bl[s][2], bl[s][5])));
                endcase
            end
            send_item(op_item(pbba_pkg::OP_FLUSH));
            drain();
        end
        calm = 1;
        drain();
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("point_box_image_bbox_accumulator_top_tb passed");
        else
            $display("point_box_image_bbox_accumulator_top_tb failed");
        $finish;
    end
endmodule

`default_nettype wire
